// ===== src/hhst_pkg.sv =====
// Shared types, codes and token functions of the HTTP header stream tokenizer.
// Used by hhst_step, hhst_outq and the top level; depends on nothing.
`default_nettype none
package hhst_pkg;

  // Width of the saturating byte counters.
  localparam int CountBits = 16;
  localparam int MaxRes    = 8;

  // Parser phases.
  localparam logic [3:0] PH_PREFIX    = 4'd0;
  localparam logic [3:0] PH_R_METHOD  = 4'd1;
  localparam logic [3:0] PH_R_URI     = 4'd2;
  localparam logic [3:0] PH_R_VERPRE  = 4'd3;
  localparam logic [3:0] PH_R_VERSION = 4'd4;
  localparam logic [3:0] PH_R_REST    = 4'd5;
  localparam logic [3:0] PH_P_VERSION = 4'd6;
  localparam logic [3:0] PH_P_CODE    = 4'd7;
  localparam logic [3:0] PH_P_REASON  = 4'd8;
  localparam logic [3:0] PH_H_NAME    = 4'd9;
  localparam logic [3:0] PH_H_VALUE   = 4'd10;
  localparam logic [3:0] PH_DONE      = 4'd11;
  localparam logic [3:0] PH_FAILED    = 4'd12;

  // Result kinds.
  localparam logic [2:0] K_METHOD  = 3'd0;
  localparam logic [2:0] K_URI     = 3'd1;
  localparam logic [2:0] K_VERSION = 3'd2;
  localparam logic [2:0] K_NAME    = 3'd3;
  localparam logic [2:0] K_VALUE   = 3'd4;
  localparam logic [2:0] K_COMMIT  = 3'd5;
  localparam logic [2:0] K_DROP    = 3'd6;
  localparam logic [2:0] K_SUMMARY = 3'd7;

  // Summary status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DATA   = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // Line flag bits.
  localparam logic [2:0] FL_BYTES    = 3'b001;
  localparam logic [2:0] FL_VALSTART = 3'b010;
  localparam logic [2:0] FL_REQUEST  = 3'b100;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [3:0]           phase;
    logic [3:0][7:0]      pbytes;
    logic [2:0]           pcnt;
    logic                 held_cr;
    logic [15:0]          code;
    logic [CountBits-1:0] bcnt;
    logic [CountBits-1:0] ccnt;
    logic [2:0]           flags;
    logic                 err;
  } st_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    tok_t [MaxRes-1:0] tok;
    logic [3:0]        n;
  } res_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_req;
    logic [15:0] code;
    logic [15:0] consumed;
  } sum_t;

  typedef struct packed {
    st_t  s;
    res_t r;
  } ctx_t;

  localparam st_t StReset = '0;

  // Byte of the "HTTP/" tag at a given position.
  function automatic logic [7:0] tag_byte(logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h48;
      3'd1:    b = 8'h54;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h50;
      3'd4:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Append one token when there is room.
  function automatic res_t put(res_t r, logic [2:0] kind, logic [7:0] b);
    res_t o;
    o = r;
    if (r.n < 4'(MaxRes)) begin
      o.tok[r.n[2:0]] = '{kind: kind, data: b};
      o.n = r.n + 4'd1;
    end
    return o;
  endfunction

  // Process one message byte that is not part of a CRLF.
  function automatic ctx_t feed(ctx_t x_in, logic [7:0] c);
    ctx_t x;
    logic [7:0] t;
    x = x_in;
    t = tag_byte(x.s.pcnt);
    case (x.s.phase)
      PH_PREFIX: begin
        if (x.s.pcnt < 3'd5 && c == t) begin
          if (x.s.pcnt >= 3'd4) begin
            x.s.pcnt = 3'd0;
            x.s.phase = PH_P_VERSION;
          end else begin
            x.s.pbytes[x.s.pcnt[1:0]] = c;
            x.s.pcnt = x.s.pcnt + 3'd1;
          end
        end else begin
          // Not a response: flush the held prefix as method bytes.
          x.s.flags = x.s.flags | FL_REQUEST;
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < x.s.pcnt) x.r = put(x.r, K_METHOD, x.s.pbytes[i]);
          end
          x.s.pcnt = 3'd0;
          if (c == CH_SPACE) x.s.phase = PH_R_URI;
          else begin
            x.s.phase = PH_R_METHOD;
            x.r = put(x.r, K_METHOD, c);
          end
        end
      end
      PH_R_METHOD: begin
        if (c == CH_SPACE) x.s.phase = PH_R_URI;
        else x.r = put(x.r, K_METHOD, c);
      end
      PH_R_URI: begin
        if (c == CH_SPACE) begin
          x.s.phase = PH_R_VERPRE;
          x.s.pcnt = 3'd0;
        end else x.r = put(x.r, K_URI, c);
      end
      PH_R_VERPRE: begin
        if (x.s.pcnt < 3'd5 && c == t) begin
          if (x.s.pcnt >= 3'd4) begin
            x.s.pcnt = 3'd0;
            x.s.phase = PH_R_VERSION;
          end else x.s.pcnt = x.s.pcnt + 3'd1;
        end else begin
          x.s.pcnt = 3'd0;
          x.s.phase = PH_R_REST;
        end
      end
      PH_R_VERSION: x.r = put(x.r, K_VERSION, c);
      PH_P_VERSION: begin
        if (c == CH_SPACE) begin
          x.s.phase = PH_P_CODE;
          x.s.code = 16'd0;
        end else x.r = put(x.r, K_VERSION, c);
      end
      PH_P_CODE: begin
        if (c == CH_SPACE) x.s.phase = PH_P_REASON;
        else if (c >= CH_ZERO && c <= CH_NINE)
          x.s.code = 16'(x.s.code * 16'd10) + {8'd0, c - CH_ZERO};
        else x.s.err = 1'b1;
      end
      PH_H_NAME: begin
        x.s.flags = x.s.flags | FL_BYTES;
        if (c == CH_COLON) x.s.phase = PH_H_VALUE;
        else x.r = put(x.r, K_NAME, c);
      end
      PH_H_VALUE: begin
        x.s.flags = x.s.flags | FL_BYTES;
        if ((x.s.flags & FL_VALSTART) != 3'd0 || c != CH_SPACE) begin
          x.s.flags = x.s.flags | FL_VALSTART;
          x.r = put(x.r, K_VALUE, c);
        end
      end
      default: ;
    endcase
    return x;
  endfunction

  // Handle a complete CRLF.
  function automatic ctx_t line_end(ctx_t x_in);
    ctx_t x;
    x = x_in;
    x.s.ccnt = x.s.bcnt;
    case (x.s.phase)
      PH_R_VERPRE, PH_R_VERSION, PH_R_REST, PH_P_CODE, PH_P_REASON: begin
        if (x.s.err) begin
          x.r = put(x.r, K_DROP, 8'd0);
          x.s.phase = PH_FAILED;
        end else begin
          x.r = put(x.r, K_COMMIT, 8'd0);
          x.s.flags = x.s.flags & FL_REQUEST;
          x.s.phase = PH_H_NAME;
        end
      end
      PH_H_NAME: begin
        if ((x.s.flags & FL_BYTES) == 3'd0) x.s.phase = PH_DONE;
        else begin
          x.r = put(x.r, K_DROP, 8'd0);
          x.s.flags = x.s.flags & FL_REQUEST;
          x.s.phase = PH_H_NAME;
        end
      end
      PH_H_VALUE: begin
        x.r = put(x.r, K_COMMIT, 8'd0);
        x.s.flags = x.s.flags & FL_REQUEST;
        x.s.phase = PH_H_NAME;
      end
      PH_DONE, PH_FAILED: ;
      default: begin
        x.r = put(x.r, K_DROP, 8'd0);
        x.s.phase = PH_FAILED;
      end
    endcase
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== src/hhst_step.sv =====
// Next-state and token logic for one input transaction of the tokenizer.
// Purely combinational; uses hhst_pkg.
`default_nettype none
module hhst_step
  import hhst_pkg::*;
(
  input  var st_t        st_i,
  input  var logic [7:0] byte_i,
  input  var logic       has_i,
  input  var logic       last_i,
  output st_t            st_o,
  output res_t           res_o,
  output sum_t           sum_o
);

  ctx_t        x;
  logic        hdr;
  logic [31:0] cwide;

  always_comb begin
    x.s = st_i;
    x.r = '0;
    sum_o = '0;
    cwide = '0;
    hdr = 1'b0;

    // Byte handling, with a CR held until the next byte is seen.
    if (has_i && x.s.phase != PH_DONE && x.s.phase != PH_FAILED) begin
      if (x.s.bcnt != '1) x.s.bcnt = x.s.bcnt + CountBits'(1);
      if (x.s.held_cr) begin
        x.s.held_cr = 1'b0;
        if (byte_i == CH_LF) x = line_end(x);
        else begin
          x = feed(x, CH_CR);
          if (byte_i == CH_CR) x.s.held_cr = 1'b1;
          else x = feed(x, byte_i);
        end
      end else if (byte_i == CH_CR) begin
        x.s.held_cr = 1'b1;
      end else begin
        x = feed(x, byte_i);
      end
    end

    // End of message: optional drop mark, summary, and return to reset.
    if (last_i) begin
      hdr = (x.s.phase == PH_H_NAME) || (x.s.phase == PH_H_VALUE);
      if (hdr && (((x.s.flags & FL_BYTES) != 3'd0) || x.s.held_cr))
        x.r = put(x.r, K_DROP, 8'd0);
      if (hdr || x.s.phase == PH_DONE) begin
        sum_o.status = ST_OK;
        sum_o.is_req = (x.s.flags & FL_REQUEST) != 3'd0;
        sum_o.code = sum_o.is_req ? 16'd0 : x.s.code;
        cwide = 32'(x.s.ccnt);
        sum_o.consumed = (cwide > 32'h0000_FFFF) ? 16'hFFFF : cwide[15:0];
      end else if (x.s.bcnt == '0 && x.s.phase == PH_PREFIX && x.s.pcnt == 3'd0
                   && !x.s.held_cr) begin
        sum_o.status = ST_NO_DATA;
      end else begin
        sum_o.status = ST_MALFORMED;
      end
      x.r = put(x.r, K_SUMMARY, 8'd0);
      x.s = StReset;
    end

    st_o = x.s;
    res_o = x.r;
  end

endmodule
`default_nettype wire

// ===== src/hhst_outq.sv =====
// Result register list: holds the tokens of one transaction and hands them out
// one per cycle while ready_i is high. Uses hhst_pkg.
`default_nettype none
module hhst_outq
  import hhst_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       load_i,
  input  var res_t       res_i,
  input  var sum_t       sum_i,
  input  var logic       ready_i,
  output logic           free_o,
  output logic           valid_o,
  output logic [2:0]     kind_o,
  output logic [7:0]     byte_o,
  output sum_t           sum_o,
  output logic           last_o
);

  tok_t [MaxRes-1:0] list_q;
  logic [3:0]        cnt_q;
  sum_t              sum_q;
  logic              pop;

  assign valid_o = cnt_q != 4'd0;
  assign pop     = valid_o && ready_i;
  assign free_o  = (cnt_q == 4'd0) || (cnt_q == 4'd1 && ready_i);
  assign kind_o  = list_q[0].kind;
  assign byte_o  = list_q[0].data;
  assign last_o  = cnt_q == 4'd1;
  assign sum_o   = (list_q[0].kind == K_SUMMARY) ? sum_q : '0;

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else if (load_i) begin
      cnt_q <= res_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  // Token payload; a pop shifts the list down by one entry.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= res_i.tok;
      sum_q  <= sum_i;
    end else if (pop) begin
      list_q <= {tok_t'('0), list_q[MaxRes-1:1]};
    end
  end

endmodule
`default_nettype wire

// ===== src/http_header_stream_tokenizer_unit.sv =====
// HTTP header stream tokenizer, top level: input register, parser state and
// result list. Depends on hhst_pkg, hhst_step and hhst_outq.
//
// One message byte enters per transaction and each transaction yields zero or
// more tagged tokens, delivered one per cycle while m_axis_tready_i is high.
// A byte can be accepted every cycle while transactions yield at most one
// result and the output is not stalled; one with more results (up to 7, on a
// prefix flush at the end of a message) holds the result list until they are
// delivered. Each byte passes the input register, then the result list. The
// summary arrives on the transaction with tlast set, after which the parser is
// back in its reset state.
`default_nettype none
module http_header_stream_tokenizer_unit
  import hhst_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  var logic [7:0]  s_axis_tdata_i,  // in_byte
  input  var logic        s_axis_tuser_i,  // has_byte
  input  var logic        s_axis_tlast_i,  // end_of_data
  output logic            m_axis_tvalid_o,
  input  var logic        m_axis_tready_i,
  // out_byte[7:0], status[9:8], is_request[10], status_code[26:11],
  // consumed[42:27], zeros[47:43]
  output logic [47:0]     m_axis_tdata_o,
  output logic [2:0]      m_axis_tuser_o,  // kind
  output logic            m_axis_tlast_o   // last_of_run
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_has_q;
  logic       in_last_q;
  st_t        st_q;
  st_t        st_d;
  res_t       res;
  sum_t       sum;
  sum_t       sum_out;
  logic       free;
  logic       consume;
  logic [2:0] kind;
  logic [7:0] obyte;

  assign consume         = in_valid_q && free;
  assign s_axis_tready_o = !in_valid_q || free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_has_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  hhst_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .has_i  (in_has_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (res),
    .sum_o  (sum)
  );

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (consume) begin
      st_q <= st_d;
    end
  end

  hhst_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (consume),
    .res_i   (res),
    .sum_i   (sum),
    .ready_i (m_axis_tready_i),
    .free_o  (free),
    .valid_o (m_axis_tvalid_o),
    .kind_o  (kind),
    .byte_o  (obyte),
    .sum_o   (sum_out),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = kind;
  assign m_axis_tdata_o = {5'd0, sum_out.consumed, sum_out.code, sum_out.is_req,
                           sum_out.status, obyte};

endmodule
`default_nettype wire

// ===== tb/http_header_stream_tokenizer_unit_tb.sv =====
// Testbench for the HTTP header stream tokenizer: directed and random messages,
// a scoreboard that predicts token streams and checks them. Depends on hhst_pkg.
`timescale 1ns / 1ps
module http_header_stream_tokenizer_unit_tb
  import hhst_pkg::*;
();

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        is_req;
    logic [15:0] code;
    logic [15:0] consumed;
    logic        last;
  } token_t;

  // Predicts the token stream of the tokenizer and checks what it delivers.
  class token_scoreboard;
    token_t      pending[$];
    int          errors;
    logic [3:0]  phase;
    logic [7:0]  pbytes[4];
    int          pcnt;
    bit          held_cr;
    logic [15:0] code;
    int          bcnt;
    int          ccnt;
    logic [2:0]  flags;
    bit          err;
    token_t      run[$];

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_PREFIX;
      foreach (pbytes[i]) pbytes[i] = 8'd0;
      pcnt = 0;
      held_cr = 0;
      code = 16'd0;
      bcnt = 0;
      ccnt = 0;
      flags = 3'd0;
      err = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] b, logic [1:0] st = 2'd0,
                       logic rq = 1'b0, logic [15:0] cd = 16'd0,
                       logic [15:0] cn = 16'd0);
      token_t t;
      t = '{kind: kind, data: b, status: st, is_req: rq, code: cd,
            consumed: cn, last: 1'b0};
      if (run.size() < MaxRes) run.push_back(t);
    endfunction

    function logic [7:0] tag_char(int pos);
      case (pos)
        0: return "H";
        1: return "T";
        2: return "T";
        3: return "P";
        default: return "/";
      endcase
    endfunction

    function void take_byte(logic [7:0] c);
      case (phase)
        PH_PREFIX: begin
          if (pcnt < 5 && c == tag_char(pcnt)) begin
            if (pcnt >= 4) begin
              pcnt = 0;
              phase = PH_P_VERSION;
            end else begin
              pbytes[pcnt] = c;
              pcnt++;
            end
          end else begin
            flags |= FL_REQUEST;
            for (int i = 0; i < pcnt; i++) emit(K_METHOD, pbytes[i]);
            pcnt = 0;
            if (c == CH_SPACE) phase = PH_R_URI;
            else begin
              phase = PH_R_METHOD;
              emit(K_METHOD, c);
            end
          end
        end
        PH_R_METHOD: begin
          if (c == CH_SPACE) phase = PH_R_URI;
          else emit(K_METHOD, c);
        end
        PH_R_URI: begin
          if (c == CH_SPACE) begin
            phase = PH_R_VERPRE;
            pcnt = 0;
          end else emit(K_URI, c);
        end
        PH_R_VERPRE: begin
          if (pcnt < 5 && c == tag_char(pcnt)) begin
            if (pcnt >= 4) begin
              pcnt = 0;
              phase = PH_R_VERSION;
            end else pcnt++;
          end else begin
            pcnt = 0;
            phase = PH_R_REST;
          end
        end
        PH_R_VERSION: emit(K_VERSION, c);
        PH_P_VERSION: begin
          if (c == CH_SPACE) begin
            phase = PH_P_CODE;
            code = 16'd0;
          end else emit(K_VERSION, c);
        end
        PH_P_CODE: begin
          if (c == CH_SPACE) phase = PH_P_REASON;
          else if (c >= CH_ZERO && c <= CH_NINE) code = 16'(code * 10 + (c - CH_ZERO));
          else err = 1;
        end
        PH_H_NAME: begin
          flags |= FL_BYTES;
          if (c == CH_COLON) phase = PH_H_VALUE;
          else emit(K_NAME, c);
        end
        PH_H_VALUE: begin
          flags |= FL_BYTES;
          if ((flags & FL_VALSTART) != 0 || c != CH_SPACE) begin
            flags |= FL_VALSTART;
            emit(K_VALUE, c);
          end
        end
        default: ;
      endcase
    endfunction

    function void finish_line();
      ccnt = bcnt;
      case (phase)
        PH_R_VERPRE, PH_R_VERSION, PH_R_REST, PH_P_CODE, PH_P_REASON: begin
          if (err) begin
            emit(K_DROP, 8'd0);
            phase = PH_FAILED;
          end else begin
            emit(K_COMMIT, 8'd0);
            flags &= FL_REQUEST;
            phase = PH_H_NAME;
          end
        end
        PH_H_NAME: begin
          if ((flags & FL_BYTES) == 0) phase = PH_DONE;
          else begin
            emit(K_DROP, 8'd0);
            flags &= FL_REQUEST;
          end
        end
        PH_H_VALUE: begin
          emit(K_COMMIT, 8'd0);
          flags &= FL_REQUEST;
          phase = PH_H_NAME;
        end
        PH_DONE, PH_FAILED: ;
        default: begin
          emit(K_DROP, 8'd0);
          phase = PH_FAILED;
        end
      endcase
    endfunction

    // Notes one accepted input transaction and queues the tokens it causes.
    function void note_input(logic [7:0] c, bit has, bit eod);
      logic [1:0] st;
      logic rq;
      logic [15:0] cd, cn;
      run.delete();
      if (has && phase != PH_DONE && phase != PH_FAILED) begin
        if (bcnt < 65535) bcnt++;
        if (held_cr) begin
          held_cr = 0;
          if (c == CH_LF) finish_line();
          else begin
            take_byte(CH_CR);
            if (c == CH_CR) held_cr = 1;
            else take_byte(c);
          end
        end else if (c == CH_CR) held_cr = 1;
        else take_byte(c);
      end
      if (eod) begin
        rq = 0; cd = 0; cn = 0;
        if ((phase == PH_H_NAME || phase == PH_H_VALUE) &&
            ((flags & FL_BYTES) != 0 || held_cr))
          emit(K_DROP, 8'd0);
        if (phase == PH_H_NAME || phase == PH_H_VALUE || phase == PH_DONE) begin
          st = ST_OK;
          rq = (flags & FL_REQUEST) != 0;
          cd = rq ? 16'd0 : code;
          cn = 16'(ccnt);
        end else if (bcnt == 0 && phase == PH_PREFIX && pcnt == 0 && !held_cr)
          st = ST_NO_DATA;
        else st = ST_MALFORMED;
        emit(K_SUMMARY, 8'd0, st, rq, cd, cn);
        clear_state();
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    // Checks one delivered result against the oldest expected token.
    function void check_result(token_t got);
      token_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected %h, got %h (kind %0d/%0d)", want, got,
                   want.kind, got.kind);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid_i, s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i, s_axis_tlast_i;
  logic        m_axis_tvalid_o, m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  token_scoreboard sb;
  bit              sending_done;

  http_header_stream_tokenizer_unit u_dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one input transaction, with a random gap ahead of it unless burst is set.
  task automatic send_item(logic [7:0] c, bit has, bit eod, bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= has;
    s_axis_tlast_i  <= eod;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(c, has, eod);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit eod, bit burst);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, eod && i == s.len() - 1, burst);
  endtask

  function automatic string pick(string opts[$]);
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  function automatic string rand_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(33, 126)))};
    return s;
  endfunction

  // Builds a mostly well-formed message with random content and occasional flaws.
  function automatic string build_message();
    string s, eol;
    int kind;
    kind = $urandom_range(0, 9);
    eol = "\r\n";
    if (kind < 5)
      s = {pick('{"GET", "POST", "HTT", "H", "PUT"}), " /", rand_text($urandom_range(0, 4)),
           " ", pick('{"HTTP/1.1", "HTTX/1", "", "HTTP/"}), eol};
    else if (kind < 9)
      s = {"HTTP/", pick('{"1.1", "1.0", ""}), " ",
           pick('{"200", "404", "", "99999", "2x0", "7"}), pick('{" OK", "", " Not Found"}),
           eol};
    else
      s = rand_text($urandom_range(1, 6));
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: s = {s, rand_text($urandom_range(1, 3)), eol};
        1: s = {s, "A\rB:  v\r\r", eol};
        default: s = {s, rand_text($urandom_range(1, 4)), ":",
                      pick('{"", " ", "  x"}), rand_text($urandom_range(0, 4)), eol};
      endcase
    end
    case ($urandom_range(0, 4))
      0: ;
      1: s = {s, "X: y"};
      2: s = {s, "\r"};
      default: s = {s, eol, rand_text($urandom_range(0, 3))};
    endcase
    return s;
  endfunction

  // Stimulus.
  initial begin
    int sent;
    string m;
    bit burst;
    sb = new();
    sending_done = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 8'd0;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Empty message, then a full request and a response without a blank line.
    send_item(8'd0, 1'b0, 1'b1, 0);
    send_text("GET / HTTP/1\r\nA: b\r\n\r\nz", 1, 1);
    send_item(8'hFF, 1'b1, 1'b0, 0);
    send_item(8'h00, 1'b0, 1'b0, 0);
    send_text("HTTP/ 20\r\n", 1, 0);
    send_text("HTTP", 1, 1);
    send_text("X\r", 1, 0);
    sent = 40;
    while (sent < 430) begin
      if ($urandom_range(0, 9) == 0) begin
        // Raw noise including empty items.
        repeat ($urandom_range(1, 8)) begin
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 7) == 0, 0);
          sent++;
        end
      end else begin
        m = build_message();
        burst = $urandom_range(0, 3) == 0;
        send_text(m, 1, burst);
        sent += m.len();
      end
    end
    send_item(8'd0, 1'b0, 1'b1, 0);
    s_axis_tvalid_i <= 1'b0;
    sending_done = 1;
  end

  // Result side: random stalls, sampling at the rising edge.
  initial begin
    int g;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = 0;
      if ($urandom_range(0, 3) == 0) g = gap_len();
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result('{kind: m_axis_tuser_o, data: m_axis_tdata_o[7:0],
                        status: m_axis_tdata_o[9:8], is_req: m_axis_tdata_o[10],
                        code: m_axis_tdata_o[26:11], consumed: m_axis_tdata_o[42:27],
                        last: m_axis_tlast_o});
  end

  // End of run.
  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/hhst_pkg.sv
src/hhst_step.sv
src/hhst_outq.sv
src/http_header_stream_tokenizer_unit.sv
tb/http_header_stream_tokenizer_unit_tb.sv
